// ===== src/cil_pkg.sv =====
package cil_pkg;

  localparam int IDX_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_GET    = 2'd2,
    REQ_SET    = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_EXEC  = 2'd1,
    S_SHIFT = 2'd2,
    S_RESP  = 2'd3
  } state_t;

  typedef enum logic [2:0] {
    MEM_NONE        = 3'd0,
    MEM_APPEND      = 3'd1,
    MEM_SET         = 3'd2,
    MEM_GET         = 3'd3,
    MEM_SHIFT_START = 3'd4,
    MEM_SHIFT       = 3'd5
  } mem_op_t;

  typedef struct packed {
    logic    req_load;
    logic    exec;
    mem_op_t mem_op;
    logic    count_dec;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    req_type_t op;
    logic      full;
    logic      in_range;
    logic      tail;
    logic      more;
  } stat_t;

endpackage

// ===== src/cil_req_if.sv =====
interface cil_req_if;
  import cil_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [IDX_W-1:0]   index;
  logic [VAL_W-1:0]   value;

  modport source (output valid, output req_type, output index, output value, input ready);
  modport sink   (input valid, input req_type, input index, input value, output ready);
endinterface

// ===== src/cil_rsp_if.sv =====
interface cil_rsp_if;
  import cil_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    read_value;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

// ===== src/cil_ram.sv =====
module cil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/cil_dp.sv =====
module cil_dp #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     in_req_type,
  input  logic [cil_pkg::IDX_W-1:0]      in_index,
  input  logic [cil_pkg::VAL_W-1:0]      in_value,
  input  cil_pkg::cmd_t                  cmd,
  output cil_pkg::stat_t                 stat,
  output logic [cil_pkg::STATUS_W-1:0]   out_status,
  output logic [cil_pkg::VAL_W-1:0]      out_read_value,
  output logic [cil_pkg::COUNT_W-1:0]    out_count
);
  import cil_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int VW = (WORD_WIDTH > VAL_W) ? WORD_WIDTH : VAL_W;
  localparam int OW = (CW > COUNT_W) ? CW : COUNT_W;

  req_type_t             op_r;
  logic [IDX_W-1:0]      idx_r;
  logic [WORD_WIDTH-1:0] val_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [AW-1:0]         ptr_r;
  logic [AW-1:0]         ptr_nxt;
  status_t               status_r;
  status_t               status_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [VAL_W-1:0]      out_rdata_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic [XW-1:0]         idx_x;
  logic [XW-1:0]         cnt_x;
  logic [XW-1:0]         ptr_x;
  logic [XW-1:0]         idx_inc;
  logic [VW-1:0]         val_ext;
  logic [VW-1:0]         rd_ext;
  logic [OW-1:0]         cnt_ext;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [WORD_WIDTH-1:0] rd_data;

  assign idx_x   = XW'(idx_r);
  assign cnt_x   = XW'(count_r);
  assign ptr_x   = XW'(ptr_r);
  assign idx_inc = idx_x + XW'(1);
  assign val_ext = VW'(in_value);
  assign rd_ext  = VW'(rd_data);
  assign cnt_ext = OW'(count_r);

  assign stat.op       = op_r;
  assign stat.full     = (count_r == CW'(CAPACITY));
  assign stat.in_range = (idx_x < cnt_x);
  assign stat.tail     = (idx_inc < cnt_x);
  assign stat.more     = ((ptr_x + XW'(1)) < cnt_x);

  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = idx_x[AW-1:0];
    wr_data    = val_r;
    rd_en      = 1'b0;
    rd_addr    = idx_x[AW-1:0];
    ptr_nxt    = ptr_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (cmd.exec) begin
      if (op_r == REQ_APPEND) begin
        status_nxt = stat.full ? ST_FULL : ST_OK;
      end else begin
        status_nxt = stat.in_range ? ST_OK : ST_RANGE;
      end
    end
    case (cmd.mem_op)
      MEM_APPEND: begin
        wr_en     = 1'b1;
        wr_addr   = count_r[AW-1:0];
        count_nxt = count_r + CW'(1);
      end
      MEM_SET: begin
        wr_en = 1'b1;
      end
      MEM_GET: begin
        rd_en = 1'b1;
      end
      MEM_SHIFT_START: begin
        rd_en   = 1'b1;
        rd_addr = idx_inc[AW-1:0];
        ptr_nxt = idx_inc[AW-1:0];
      end
      MEM_SHIFT: begin
        // entry read last cycle at ptr moves down one place
        wr_en   = 1'b1;
        wr_addr = AW'(ptr_r - 1'b1);
        wr_data = rd_data;
        if (stat.more) begin
          rd_en   = 1'b1;
          rd_addr = AW'(ptr_r + 1'b1);
          ptr_nxt = AW'(ptr_r + 1'b1);
        end
      end
      default: begin
      end
    endcase
    if (cmd.count_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      op_r  <= req_type_t'(in_req_type);
      idx_r <= in_index;
      val_r <= val_ext[WORD_WIDTH-1:0];
    end
    ptr_r    <= ptr_nxt;
    status_r <= status_nxt;
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_rdata_r  <= (op_r == REQ_GET && status_r == ST_OK) ? rd_ext[VAL_W-1:0] : '0;
      out_count_r  <= cnt_ext[COUNT_W-1:0];
    end
  end

  cil_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_status     = out_status_r;
  assign out_read_value = out_rdata_r;
  assign out_count      = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_shift_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_op == MEM_SHIFT |-> ptr_x < cnt_x)
    else $error("shift source beyond list end");
`endif

endmodule

// ===== src/cil_ctrl.sv =====
module cil_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  cil_pkg::stat_t stat,
  output cil_pkg::cmd_t  cmd
);
  import cil_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mem_op    = MEM_NONE;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
        if (stat.op == REQ_APPEND) begin
          if (!stat.full) begin
            cmd.mem_op = MEM_APPEND;
          end
        end else if (stat.in_range) begin
          unique case (stat.op)
            REQ_REMOVE: begin
              if (stat.tail) begin
                cmd.mem_op = MEM_SHIFT_START;
                state_nxt  = S_SHIFT;
              end else begin
                cmd.count_dec = 1'b1;
              end
            end
            REQ_GET:    cmd.mem_op = MEM_GET;
            REQ_SET:    cmd.mem_op = MEM_SET;
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd.mem_op = MEM_SHIFT;
        if (!stat.more) begin
          cmd.count_dec = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("accepted beat not executed next cycle");

  a_shift_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> stat.op == REQ_REMOVE)
    else $error("shift sequence without remove");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load did not raise valid");
`endif

endmodule

// ===== src/compacting_indexed_list_top.sv =====
// Flow: an accepted request passes S_EXEC and S_RESP; its result beat is loaded once the
//   output is free. A remove adds S_SHIFT, which moves (count - index - 1) entries down.
//   A new request is accepted only in S_IDLE, after the previous result is loaded; the
//   single-port-write entry RAM moves one entry per cycle during the shift.
// Reset: synchronous active-low rst_n clears the count, controller state and output
//   valid; the entry RAM is not cleared and entries are read only after being written.
module compacting_indexed_list_top #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  cil_req_if.sink  in_chan,
  cil_rsp_if.source out_chan
);
  import cil_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cil_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cil_dp #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_chan.req_type),
    .in_index       (in_chan.index),
    .in_value       (in_chan.value),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_chan.status),
    .out_read_value (out_chan.read_value),
    .out_count      (out_chan.count)
  );

endmodule
